// File: hw/rtl/cfb_pkg.sv
// ----------------------------------------------------------------------------
// cfb_pkg
// Shared types, constants and the CRC-16 byte update for the frame builder.
// ----------------------------------------------------------------------------
package cfb_pkg;

   localparam logic [7:0]  SYNC_BYTE = 8'hFF;
   localparam logic [15:0] CRC_POLY  = 16'h1021;
   localparam logic [15:0] CRC_INIT  = 16'hFFFF;

   localparam logic OP_START   = 1'b0;
   localparam logic OP_PAYLOAD = 1'b1;

   localparam int CFB_QUEUE_DEPTH = 4;

   // byte positions within a frame
   localparam logic [2:0] POS_SYNC   = 3'd0;
   localparam logic [2:0] POS_LEN    = 3'd1;
   localparam logic [2:0] POS_BODY   = 3'd2;
   localparam logic [2:0] POS_CRC_HI = 3'd3;
   localparam logic [2:0] POS_CRC_LO = 3'd4;

   typedef struct packed {
      logic        is_start;
      logic        trailer;
      logic [7:0]  length;
      logic [7:0]  body;
      logic [15:0] crc;
   } job_type;

   // shift-in form, MSB first, no augmentation
   function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                            input logic [7:0]  data);
      logic [15:0] r;
      logic        c;
      r = crc;
      for (int k = 7; k >= 0; k--) begin
         c = r[15];
         r = {r[14:0], data[k]};
         if (c) begin
            r = r ^ CRC_POLY;
         end
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/cfb_front.sv
// ----------------------------------------------------------------------------
// cfb_front
// Accepts transactions, tracks frame state and CRC, and queues output jobs.
// ----------------------------------------------------------------------------
module cfb_front
   import cfb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic       req_operation,
   input  logic [7:0] req_payload_length,
   input  logic [7:0] req_command_code,
   input  logic [7:0] req_payload_byte,
   output logic       push,
   output job_type    push_job
);

   logic [15:0] crc_ff, crc_in;
   logic [7:0]  remaining_ff, remaining_in;
   logic        open_ff, open_in;
   logic        accept;

   assign accept = req_valid && !req_stall;

   always_comb begin
      crc_in            = crc_ff;
      remaining_in      = remaining_ff;
      open_in           = open_ff;
      push              = 1'b0;
      push_job.is_start = (req_operation == OP_START);
      push_job.trailer  = 1'b0;
      push_job.length   = req_payload_length;
      push_job.body     = req_payload_byte;
      push_job.crc      = crc_ff;
      if (accept) begin
         if (req_operation == OP_START) begin
            crc_in           = crc_byte(crc_byte(CRC_INIT, req_payload_length),
                                        req_command_code);
            remaining_in     = req_payload_length;
            open_in          = (req_payload_length != 8'd0);
            push             = 1'b1;
            push_job.body    = req_command_code;
            push_job.trailer = (req_payload_length == 8'd0);
            push_job.crc     = crc_in;
         end else if (open_ff) begin
            crc_in           = crc_byte(crc_ff, req_payload_byte);
            remaining_in     = remaining_ff - 8'd1;
            open_in          = (remaining_ff != 8'd1);
            push             = 1'b1;
            push_job.trailer = (remaining_ff == 8'd1);
            push_job.crc     = crc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= CRC_INIT;
         remaining_ff <= 8'd0;
         open_ff      <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         remaining_ff <= remaining_in;
         open_ff      <= open_in;
      end
   end

endmodule

// File: hw/rtl/cfb_queue.sv
// ----------------------------------------------------------------------------
// cfb_queue
// Small job queue between the front and back sections.
// ----------------------------------------------------------------------------
module cfb_queue
   import cfb_pkg::*;
#(
   parameter int QUEUE_DEPTH = CFB_QUEUE_DEPTH
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head_job,
   output logic    empty,
   output logic    full
);

   localparam int PtrWidth   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CountWidth = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PtrWidth-1:0]   LastPtr   = PtrWidth'(QUEUE_DEPTH - 1);
   localparam logic [CountWidth-1:0] DepthCount = CountWidth'(QUEUE_DEPTH);

   job_type                 entry_ff [QUEUE_DEPTH];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]   count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == DepthCount);
   assign head_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: hw/rtl/cfb_back.sv
// ----------------------------------------------------------------------------
// cfb_back
// Walks each queued job byte by byte into the registered output channel.
// ----------------------------------------------------------------------------
module cfb_back
   import cfb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  job_type    head_job,
   input  logic       empty,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_frame_byte,
   output logic       rsp_frame_end
);

   logic [2:0] offset_ff, offset_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       end_ff, end_in;
   logic       advance;
   logic       take;
   logic [2:0] pos;
   logic [2:0] last_pos;
   logic [7:0] pos_byte;

   assign advance  = !valid_ff || !rsp_stall;
   assign take     = advance && !empty;
   assign pos      = offset_ff + (head_job.is_start ? POS_SYNC : POS_BODY);
   assign last_pos = head_job.trailer ? POS_CRC_LO : POS_BODY;
   assign pop      = take && (pos == last_pos);

   always_comb begin
      unique case (pos)
         POS_SYNC:   pos_byte = SYNC_BYTE;
         POS_LEN:    pos_byte = head_job.length;
         POS_BODY:   pos_byte = head_job.body;
         POS_CRC_HI: pos_byte = head_job.crc[15:8];
         POS_CRC_LO: pos_byte = head_job.crc[7:0];
         default:    pos_byte = SYNC_BYTE;
      endcase
   end

   always_comb begin
      offset_in = offset_ff;
      valid_in  = valid_ff;
      byte_in   = byte_ff;
      end_in    = end_ff;
      if (advance) begin
         valid_in = !empty;
         if (take) begin
            byte_in   = pos_byte;
            end_in    = (pos == POS_CRC_LO);
            offset_in = pop ? 3'd0 : offset_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= 3'd0;
         valid_ff  <= 1'b0;
      end else begin
         offset_ff <= offset_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      end_ff  <= end_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_frame_byte = byte_ff;
   assign rsp_frame_end  = end_ff;

endmodule

// File: hw/rtl/command_frame_builder_crc16_core.sv
// ----------------------------------------------------------------------------
// command_frame_builder_crc16_core
// Serial command frame builder with CRC-16 (0x1021, shift-in form).
// ----------------------------------------------------------------------------
// A start transaction yields 0xFF, length and opcode, followed by the CRC high
// and low bytes when the length is zero; each payload transaction inside an
// open frame yields its byte, plus the two CRC bytes after the last one, with
// rsp_frame_end set on the CRC low byte. Payload outside a frame is dropped
// and a start inside a frame restarts it. The front section takes one request
// per cycle while the queue is not full and updates the CRC in that cycle; the
// back section emits one byte per cycle, while jobs are queued and rsp_stall is
// low, through a single output register, so a payload transaction yields one
// byte, a start three (five at length zero) and a last payload byte three. A
// queue of QUEUE_DEPTH jobs absorbs these bursts; req_stall rises only while it is full.
// ----------------------------------------------------------------------------
module command_frame_builder_crc16_core
   import cfb_pkg::*;
#(
   parameter int QUEUE_DEPTH = CFB_QUEUE_DEPTH
)(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_operation,
   input  logic [7:0] req_payload_length,
   input  logic [7:0] req_command_code,
   input  logic [7:0] req_payload_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_frame_byte,
   output logic       rsp_frame_end
);

   logic    push;
   job_type push_job;
   logic    pop;
   job_type head_job;
   logic    empty;
   logic    full;

   assign req_stall = full;

   cfb_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_payload_length (req_payload_length),
      .req_command_code   (req_command_code),
      .req_payload_byte   (req_payload_byte),
      .push               (push),
      .push_job           (push_job)
   );

   cfb_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .empty    (empty),
      .full     (full)
   );

   cfb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_job       (head_job),
      .empty          (empty),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_frame_end  (rsp_frame_end)
   );

endmodule

// File: sim/tb_command_frame_builder_crc16_core.sv
// ----------------------------------------------------------------------------
// tb_command_frame_builder_crc16_core
// Self-checking bench for the command frame builder: a directed table then
// random well-formed, truncated and stray transactions. Every response byte
// is compared in order against a local frame/CRC predictor or typed row bytes.
// ----------------------------------------------------------------------------
module tb_command_frame_builder_crc16_core
   import cfb_pkg::*;
();

   localparam int FROM_MODEL   = -1;
   localparam int RANDOM_ITEMS = 430;
   localparam int HOLD_CYCLES  = 60;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct {
      logic       op;
      logic [7:0] length;
      logic [7:0] opcode;
      logic [7:0] data;
      int         typed_n;
      logic [7:0] typed [3];
   } stim_row_type;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } link_byte_type;

   logic       clock              = 1'b0;
   logic       reset              = 1'b1;
   logic       req_valid          = 1'b0;
   logic       req_operation      = 1'b0;
   logic [7:0] req_payload_length = 8'h00;
   logic [7:0] req_command_code   = 8'h00;
   logic [7:0] req_payload_byte   = 8'h00;
   logic       rsp_stall          = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic [7:0] rsp_frame_byte;
   logic       rsp_frame_end;

   logic [15:0] model_crc  = CRC_INIT;
   logic [7:0]  model_left = 8'h00;
   logic        model_open = 1'b0;

   link_byte_type link_bytes_due [$];
   stim_row_type  directed_rows [$];

   int  mismatch_count = 0;
   int  cycle_count    = 0;
   int  counted_items  = 0;
   bit  sender_quiet   = 1'b0;
   bit  receiver_quiet = 1'b0;
   bit  start_hold     = 1'b0;

   command_frame_builder_crc16_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_payload_length (req_payload_length),
      .req_command_code   (req_command_code),
      .req_payload_byte   (req_payload_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_frame_byte     (rsp_frame_byte),
      .rsp_frame_end      (rsp_frame_end)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("command_frame_builder_crc16_core verification failed");
         $finish;
      end
   end

   function automatic logic [15:0] crc16_shift_in(input logic [15:0] acc,
                                                  input logic [7:0]  octet);
      logic [15:0] nxt;
      nxt = acc;
      for (int i = 7; i >= 0; i--) begin
         nxt = {nxt[14:0], octet[i]} ^ (nxt[15] ? CRC_POLY : 16'h0000);
      end
      return nxt;
   endfunction

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      $display("MISMATCH cycle %0d: %s", cycle_count, what);
   endtask

   task automatic queue_frame_bytes(input stim_row_type row);
      link_byte_type built [$];
      bit            close;
      close = 1'b0;
      if (row.op == OP_START) begin
         model_crc = crc16_shift_in(crc16_shift_in(CRC_INIT, row.length), row.opcode);
         built.push_back(link_byte_type'{SYNC_BYTE, 1'b0});
         built.push_back(link_byte_type'{row.length, 1'b0});
         built.push_back(link_byte_type'{row.opcode, 1'b0});
         if (row.length == 8'h00) begin
            close = 1'b1;
         end else begin
            model_open = 1'b1;
            model_left = row.length;
         end
      end else if (model_open) begin
         model_crc = crc16_shift_in(model_crc, row.data);
         built.push_back(link_byte_type'{row.data, 1'b0});
         model_left = model_left - 8'd1;
         close = (model_left == 8'h00);
      end
      if (close) begin
         built.push_back(link_byte_type'{model_crc[15:8], 1'b0});
         built.push_back(link_byte_type'{model_crc[7:0], 1'b1});
         model_open = 1'b0;
         model_left = 8'h00;
      end
      if (row.typed_n != FROM_MODEL) begin
         built.delete();
         for (int k = 0; k < row.typed_n; k++) begin
            built.push_back(link_byte_type'{row.typed[k], 1'b0});
         end
      end
      foreach (built[k]) begin
         link_bytes_due.push_back(built[k]);
      end
   endtask

   task automatic deliver_row(input stim_row_type row);
      while (!sender_quiet && $urandom_range(0, 99) < 22) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_operation      <= row.op;
      req_payload_length <= row.length;
      req_command_code   <= row.opcode;
      req_payload_byte   <= row.data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      queue_frame_bytes(row);
   endtask

   task automatic offer(input logic op, input logic [7:0] len);
      stim_row_type row;
      if (!(op == OP_PAYLOAD && !model_open)) begin
         counted_items++;
      end
      row.op      = op;
      row.length  = (op == OP_START) ? len : 8'($urandom_range(0, 255));
      row.opcode  = 8'($urandom_range(0, 255));
      row.data    = 8'($urandom_range(0, 255));
      row.typed_n = FROM_MODEL;
      row.typed   = '{8'h00, 8'h00, 8'h00};
      deliver_row(row);
   endtask

   // receiver: random stall, quiet stretch, and one long hold-off
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (start_hold) begin
            start_hold = 1'b0;
            hold_left  = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else if (receiver_quiet) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 22);
         end
      end
   end

   always @(posedge clock) begin
      link_byte_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (link_bytes_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected byte %02h end %0b",
                                    rsp_frame_byte, rsp_frame_end));
         end else begin
            due = link_bytes_due.pop_front();
            if (rsp_frame_byte !== due.value) begin
               flag_mismatch($sformatf("frame_byte %02h, want %02h",
                                       rsp_frame_byte, due.value));
            end
            if (rsp_frame_end !== due.last) begin
               flag_mismatch($sformatf("frame_end %0b, want %0b",
                                       rsp_frame_end, due.last));
            end
         end
      end
   end

   initial begin : stimulus
      int  pick;
      int  len;
      bit  pressure_done;
      pressure_done = 1'b0;

      // op, length, opcode, data, typed count, typed header bytes
      directed_rows.push_back('{OP_PAYLOAD, 8'h00, 8'h00, 8'h00, 0, '{8'h00, 8'h00, 8'h00}});
      directed_rows.push_back('{OP_PAYLOAD, 8'hFF, 8'hFF, 8'hFF, 0, '{8'h00, 8'h00, 8'h00}});
      directed_rows.push_back('{OP_START, 8'h00, 8'h00, 8'h00, FROM_MODEL,
                                '{8'h00, 8'h00, 8'h00}});
      directed_rows.push_back('{OP_START, 8'h00, 8'hFF, 8'hFF, FROM_MODEL,
                                '{8'h00, 8'h00, 8'h00}});
      directed_rows.push_back('{OP_PAYLOAD, 8'h11, 8'h22, 8'hA5, 0, '{8'h00, 8'h00, 8'h00}});
      directed_rows.push_back('{OP_START, 8'h01, 8'h80, 8'h00, 3, '{8'hFF, 8'h01, 8'h80}});
      directed_rows.push_back('{OP_PAYLOAD, 8'h00, 8'h00, 8'hFF, FROM_MODEL,
                                '{8'h00, 8'h00, 8'h00}});
      directed_rows.push_back('{OP_START, 8'h03, 8'h01, 8'hFF, 3, '{8'hFF, 8'h03, 8'h01}});
      directed_rows.push_back('{OP_PAYLOAD, 8'hFF, 8'hFF, 8'h00, FROM_MODEL,
                                '{8'h00, 8'h00, 8'h00}});
      directed_rows.push_back('{OP_PAYLOAD, 8'h00, 8'h00, 8'hFF, FROM_MODEL,
                                '{8'h00, 8'h00, 8'h00}});
      // restart inside an open frame
      directed_rows.push_back('{OP_START, 8'h02, 8'h7F, 8'h00, 3, '{8'hFF, 8'h02, 8'h7F}});
      directed_rows.push_back('{OP_PAYLOAD, 8'h00, 8'h00, 8'h80, FROM_MODEL,
                                '{8'h00, 8'h00, 8'h00}});
      directed_rows.push_back('{OP_PAYLOAD, 8'h00, 8'h00, 8'h01, FROM_MODEL,
                                '{8'h00, 8'h00, 8'h00}});
      directed_rows.push_back('{OP_START, 8'hFF, 8'hFF, 8'hFF, 3, '{8'hFF, 8'hFF, 8'hFF}});
      directed_rows.push_back('{OP_PAYLOAD, 8'h00, 8'h00, 8'h3C, FROM_MODEL,
                                '{8'h00, 8'h00, 8'h00}});
      directed_rows.push_back('{OP_START, 8'h04, 8'h55, 8'h00, 3, '{8'hFF, 8'h04, 8'h55}});
      directed_rows.push_back('{OP_PAYLOAD, 8'hFF, 8'hFF, 8'h00, FROM_MODEL,
                                '{8'h00, 8'h00, 8'h00}});
      directed_rows.push_back('{OP_PAYLOAD, 8'h00, 8'h00, 8'hFF, FROM_MODEL,
                                '{8'h00, 8'h00, 8'h00}});
      directed_rows.push_back('{OP_PAYLOAD, 8'h00, 8'h00, 8'h5A, FROM_MODEL,
                                '{8'h00, 8'h00, 8'h00}});
      directed_rows.push_back('{OP_PAYLOAD, 8'h00, 8'h00, 8'hA5, FROM_MODEL,
                                '{8'h00, 8'h00, 8'h00}});
      directed_rows.push_back('{OP_PAYLOAD, 8'hAA, 8'h55, 8'h3C, 0, '{8'h00, 8'h00, 8'h00}});

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         deliver_row(directed_rows[i]);
      end

      while (counted_items < RANDOM_ITEMS) begin
         sender_quiet   = (counted_items >= 150 && counted_items < 230);
         receiver_quiet = sender_quiet;
         pick = $urandom_range(0, 99);
         if (!pressure_done && counted_items >= 300) begin
            // receiver holds off while a long frame streams in
            pressure_done = 1'b1;
            sender_quiet  = 1'b1;
            start_hold    = 1'b1;
            offer(OP_START, 8'd40);
            repeat (40) offer(OP_PAYLOAD, 8'h00);
            sender_quiet  = 1'b0;
         end else if (pick < 80) begin
            len = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 6) : $urandom_range(7, 24);
            offer(OP_START, 8'(len));
            repeat (len) offer(OP_PAYLOAD, 8'h00);
         end else if (pick < 92) begin
            // truncated frame, cut short by the next start
            len = $urandom_range(2, 255);
            offer(OP_START, 8'(len));
            repeat ($urandom_range(0, (len > 8) ? 7 : len - 1)) offer(OP_PAYLOAD, 8'h00);
            offer(OP_START, 8'($urandom_range(0, 3)));
         end else begin
            repeat ($urandom_range(1, 3)) offer(OP_PAYLOAD, 8'h00);
         end
      end

      req_valid      <= 1'b0;
      sender_quiet   = 1'b0;
      receiver_quiet = 1'b0;
      while (link_bytes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("command_frame_builder_crc16_core verification clean");
      end else begin
         $display("command_frame_builder_crc16_core verification failed");
      end
      $finish;
   end

endmodule
